@@ hdl/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by b2da_core and binary_to_decimal_ascii.
package b2da_pkg;

    localparam int VALUE_BITS_DEF = 32;

    // ASCII '0'; fits the 6-bit character field
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Decimal digits needed for the largest value of a given width:
    // floor(bits * log10(2)) + 1
    function automatic int dec_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // Commands from the sequencer to the shift-add unit
    typedef struct packed {
        logic load;       // capture a new value, clear the BCD register
        logic step;       // one double-dabble iteration
        logic shift_out;  // drop the top BCD digit
    } core_ctrl_t;

endpackage

@@ hdl/b2da_core.sv @@
// Shift-add-3 (double dabble) datapath: binary shift register plus BCD register.
// Depends on b2da_pkg for the control struct.
module b2da_core
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  core_ctrl_t            ctrl,
    input  logic [VALUE_BITS-1:0] value,
    output logic [3:0]            top_digit
);

    localparam int NDIG  = dec_digits(VALUE_BITS);
    localparam int BCD_W = NDIG * 4;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (ctrl.step)
        begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
        end
        else if (ctrl.shift_out)
        begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'b0000};
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

@@ hdl/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter: sequencer and output register.
// Depends on b2da_pkg and b2da_core.
//
// Usage:
//   Input channel (in_valid / in_stall / value): one beat carries one unsigned
//   VALUE_BITS-bit number. in_stall is high for the whole conversion, so one
//   number is in flight at a time.
//   Output channel (out_valid / out_stall / digit_char / last_digit): one beat
//   per decimal digit, ASCII, most significant first, no leading zeros. Zero
//   gives the single digit '0'. last_digit marks the final beat of a number.
//   Sequence: accept the number, run shift-add-3 over every value bit in the
//   BCD unit, skip each leading zero, leave the skip state, then send each
//   digit. Leading zeros plus digits always total dec_digits(VALUE_BITS).
//   Output stall: the digit sits in the output register until taken; the
//   sequencer waits in the emit state and the BCD register holds.
//   Reset: returns to idle with no output beat pending; the datapath holds no
//   state that needs clearing.
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [5:0]            digit_char,
    output logic                  last_digit
);

    localparam int NDIG  = dec_digits(VALUE_BITS);
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int DIG_W = $clog2(NDIG);

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);
    localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NDIG - 1);

    state_t           state_reg, state_next;
    logic [BIT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0] dig_cnt_reg, dig_cnt_next;   // digits left after the top one
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       digit_reg;
    logic             last_reg;

    core_ctrl_t       ctrl;
    logic [3:0]       top_digit;
    logic             in_accept;
    logic             out_free;   // output register empty or being taken
    logic             load_out;

    b2da_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk       (clk),
        .ctrl      (ctrl),
        .value     (value),
        .top_digit (top_digit)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        ctrl           = '0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ctrl.load    = 1'b1;
                    bit_cnt_next = BIT_LAST;
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.step = 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_LAST;
                    state_next   = ST_SKIP;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, but always keep the units digit
                if (top_digit == 4'd0 && dig_cnt_reg != '0)
                begin
                    ctrl.shift_out = 1'b1;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    ctrl.shift_out = 1'b1;
                    if (dig_cnt_reg == '0)
                        state_next = ST_IDLE;
                    else
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            digit_reg <= ASCII_ZERO + {2'b00, top_digit};
            last_reg  <= (dig_cnt_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_reg;
    assign last_digit = last_reg;

    // ---- assertions ----
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_CONVERT)
        else $error("accepted beat did not start a conversion");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + 6'd9))
        else $error("digit out of ASCII range");

    a_convert_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT && bit_cnt_reg == '0) |=> state_reg == ST_SKIP)
        else $error("conversion did not end after the last bit");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && dig_cnt_reg == '0 && out_free)
        |=> (state_reg == ST_IDLE && out_valid && last_digit))
        else $error("final digit not flagged or run not closed");

endmodule
